/* rtl/seven_segment_text_mux_driver_defines.svh */
// ----------------------------------------------------------------------------
// seven segment text mux driver - assertion macros
// concurrent check helpers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TEXT_MUX_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_TEXT_MUX_DRIVER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on i_clk, off during reset
`define SSTMD_ASSERT_IMPL(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("sstmd check failed");
// next-cycle implication
`define SSTMD_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("sstmd check failed");
`else
`define SSTMD_ASSERT_IMPL(lbl, ant, con)
`define SSTMD_ASSERT_NEXT(lbl, ant, con)
`endif

`endif

/* rtl/sstmd_pkg.sv */
// ----------------------------------------------------------------------------
// sstmd_pkg
// shared types, segment codes and the character map
// ----------------------------------------------------------------------------
`default_nettype none

package sstmd_pkg;

    localparam int DIGITS_DEF = 4;
    localparam int Q_DEPTH    = 2;

    typedef logic [1:0] t_mode;
    typedef logic [7:0] t_char;
    typedef logic [7:0] t_seg;
    typedef logic [3:0] t_en;

    localparam t_mode MODE_START = 2'd0;
    localparam t_mode MODE_CHAR  = 2'd1;
    localparam t_mode MODE_TICK  = 2'd2;

    localparam t_char CHAR_NUL   = 8'h00;
    localparam t_char CHAR_SPACE = 8'h20;
    localparam t_char CHAR_DASH  = 8'h2D;
    localparam t_char CHAR_DOT   = 8'h2E;
    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_NINE  = 8'h39;

    localparam t_seg SEG_BLANK = 8'b0000_0000;
    localparam t_seg SEG_DOT   = 8'b1000_0000;
    localparam t_seg SEG_DASH  = 8'b0100_0000;
    localparam t_seg SEG_ERROR = 8'b0100_1111;

    localparam t_seg NUMERALS [10] = '{
        8'b0011_1111, 8'b0000_0110, 8'b0101_1011, 8'b0100_1111, 8'b0110_0110,
        8'b0110_1101, 8'b0111_1101, 8'b0000_0111, 8'b0111_1111, 8'b0110_1111
    };

    typedef enum logic [1:0] {
        KIND_START,
        KIND_CHAR,
        KIND_TICK
    } t_kind;

    // classified command handed from the front end to the back end
    typedef struct packed {
        t_kind kind;
        logic  is_nul;
        logic  is_dot;
        logic  known;
        t_seg  pattern;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic known;
        t_seg pattern;
    } t_lookup;

    function automatic t_lookup seg_lookup(input t_char c);
        t_lookup r;
        r.known   = 1'b1;
        r.pattern = SEG_BLANK;
        case (c) inside
            [CHAR_ZERO:CHAR_NINE]: r.pattern = NUMERALS[4'(c - CHAR_ZERO)];
            CHAR_DOT:              r.pattern = SEG_DOT;
            CHAR_DASH:             r.pattern = SEG_DASH;
            CHAR_SPACE:            r.pattern = SEG_BLANK;
            default:               r.known   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/sstmd_if.sv */
// ----------------------------------------------------------------------------
// sstmd channel interfaces
// valid/ready channels for text input and display output
// ----------------------------------------------------------------------------
`default_nettype none

interface sstmd_in_if;
    logic               valid;
    logic               ready;
    sstmd_pkg::t_mode   mode;
    sstmd_pkg::t_char   ch;

    modport source (output valid, output mode, output ch, input ready);
    modport sink   (input valid, input mode, input ch, output ready);
endinterface

interface sstmd_out_if;
    logic               valid;
    logic               ready;
    sstmd_pkg::t_seg    segment_lines;
    sstmd_pkg::t_en     digit_enables;

    modport source (output valid, output segment_lines, output digit_enables, input ready);
    modport sink   (input valid, input segment_lines, input digit_enables, output ready);
endinterface

`default_nettype wire

/* rtl/sstmd_front.sv */
// ----------------------------------------------------------------------------
// sstmd_front
// accepts input transactions, decodes mode and maps the character
// ----------------------------------------------------------------------------
`default_nettype none

module sstmd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sstmd_in_if.sink          i_in,
    output sstmd_pkg::t_cmd   o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready
);
    import sstmd_pkg::*;

    logic    r_valid;
    t_cmd    r_cmd;
    logic    n_valid;
    t_cmd    n_cmd;
    logic    accept;
    t_lookup lk;

    assign i_in.ready  = !r_valid || i_cmd_ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;
    assign lk          = seg_lookup(i_in.ch);

    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        n_cmd   = r_cmd;
        if (accept) begin
            n_cmd.is_nul  = (i_in.ch == CHAR_NUL);
            n_cmd.is_dot  = (i_in.ch == CHAR_DOT);
            n_cmd.known   = lk.known;
            n_cmd.pattern = lk.pattern;
            case (i_in.mode)
                MODE_START: begin
                    n_cmd.kind = KIND_START;
                    n_valid    = 1'b1;
                end
                MODE_CHAR: begin
                    n_cmd.kind = KIND_CHAR;
                    n_valid    = 1'b1;
                end
                MODE_TICK: begin
                    n_cmd.kind = KIND_TICK;
                    n_valid    = 1'b1;
                end
                default: begin
                    // unused mode is taken and dropped
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

/* rtl/sstmd_queue.sv */
// ----------------------------------------------------------------------------
// sstmd_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module sstmd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sstmd_pkg::t_cmd      i_cmd,
    input  logic                 i_valid,
    output logic                 o_ready,
    output sstmd_pkg::t_cmd      o_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sstmd_pkg::t_q_status o_status
);
    import sstmd_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    assign full     = (r_count == CW'(Q_DEPTH));
    assign empty    = (r_count == '0);
    assign o_ready  = !full;
    assign o_valid  = !empty;
    assign o_cmd    = r_mem[r_rd];
    assign push     = i_valid && !full;
    assign pop      = o_valid && i_ready;
    assign o_status = '{full: full, empty: empty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/sstmd_back.sv */
// ----------------------------------------------------------------------------
// sstmd_back
// digit pattern store, text placement and refresh scan
// ----------------------------------------------------------------------------
`default_nettype none

module sstmd_back #(
    parameter int DIGITS = sstmd_pkg::DIGITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sstmd_pkg::t_cmd  i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    sstmd_out_if.source      o_out
);
    import sstmd_pkg::*;

    localparam int WW = $clog2(DIGITS + 1);
    localparam int SW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    t_seg          r_pat [DIGITS];
    logic [WW-1:0] r_wd;
    logic          r_prev;
    logic          r_seen;
    logic          r_halt;
    logic [SW-1:0] r_scan;
    logic          r_out_valid;
    t_seg          r_seg;
    t_en           r_en;

    t_seg          n_pat [DIGITS];
    logic [WW-1:0] n_wd;
    logic          n_prev;
    logic          n_seen;
    logic          n_halt;
    logic [SW-1:0] n_scan;
    logic          n_out_valid;
    t_seg          n_seg;
    t_en           n_en;

    logic [WW-1:0] target;
    logic [SW-1:0] en_idx;
    t_seg          scan_pat;
    logic          pop;

    assign o_cmd_ready   = (i_cmd.kind != KIND_TICK) || !r_out_valid || o_out.ready;
    assign pop           = i_cmd_valid && o_cmd_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.segment_lines = r_seg;
    assign o_out.digit_enables = r_en;

    // a dot after a non-dot stays on the current digit
    assign target = (r_seen && (r_prev || !i_cmd.is_dot)) ? r_wd + WW'(1) : r_wd;
    assign en_idx = SW'(DIGITS - 1) - r_scan;

    always_comb begin
        scan_pat = SEG_BLANK;
        for (int i = 0; i < DIGITS; i++) begin
            if (SW'(i) == r_scan) begin
                scan_pat = r_pat[i];
            end
        end
    end

    always_comb begin
        n_pat       = r_pat;
        n_wd        = r_wd;
        n_prev      = r_prev;
        n_seen      = r_seen;
        n_halt      = r_halt;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !o_out.ready;
        n_seg       = r_seg;
        n_en        = r_en;
        if (pop) begin
            case (i_cmd.kind)
                KIND_START: begin
                    for (int i = 0; i < DIGITS; i++) begin
                        n_pat[i] = SEG_BLANK;
                    end
                    n_wd   = '0;
                    n_prev = 1'b0;
                    n_seen = 1'b0;
                    n_halt = 1'b0;
                end
                KIND_CHAR: begin
                    if (!r_halt) begin
                        if (i_cmd.is_nul) begin
                            n_halt = 1'b1;
                        end else if (target >= WW'(DIGITS)) begin
                            n_halt = 1'b1;
                        end else if (!i_cmd.known) begin
                            for (int i = 0; i < DIGITS; i++) begin
                                n_pat[i] = SEG_ERROR;
                            end
                            n_halt = 1'b1;
                        end else begin
                            for (int i = 0; i < DIGITS; i++) begin
                                if (WW'(i) == target) begin
                                    n_pat[i] = r_pat[i] | i_cmd.pattern;
                                end
                            end
                            n_wd   = target;
                            n_prev = i_cmd.is_dot;
                            n_seen = 1'b1;
                        end
                    end
                end
                KIND_TICK: begin
                    n_out_valid = 1'b1;
                    n_seg       = ~scan_pat;
                    for (int b = 0; b < 4; b++) begin
                        n_en[b] = (4'(en_idx) == 4'(b));
                    end
                    n_scan = (r_scan == SW'(DIGITS - 1)) ? '0 : r_scan + SW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_pat[i] <= SEG_BLANK;
            end
            r_wd        <= '0;
            r_prev      <= 1'b0;
            r_seen      <= 1'b0;
            r_halt      <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pat       <= n_pat;
            r_wd        <= n_wd;
            r_prev      <= n_prev;
            r_seen      <= n_seen;
            r_halt      <= n_halt;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
        r_en  <= n_en;
    end

endmodule

`default_nettype wire

/* rtl/seven_segment_text_mux_driver.sv */
// ----------------------------------------------------------------------------
// seven_segment_text_mux_driver
// text to seven-segment digits with a multiplexed refresh scan
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                        | notes
//   ---------+-----+--------------------------------+-----------------------------
//   i_in     | in  | mode[1:0], ch[7:0]             | start, character or tick
//   o_out    | out | segment_lines[7:0], digit_en[3:0] | one transaction per tick
//
//   one transaction per clock sustained while o_out is not stalled, through the
//   front end decode register, a two-entry command queue and the back end state update
//   o_out goes valid from the back end output register once a tick has passed them
//   a character or start transaction produces no output transaction
//   reset is synchronous, active low; digits come up blank, scan at digit 0
//   a stall on o_out holds ticks in the queue and backs up into i_in
//
// ----------------------------------------------------------------------------
`default_nettype none
`include "seven_segment_text_mux_driver_defines.svh"

module seven_segment_text_mux_driver #(
    parameter int DIGITS = sstmd_pkg::DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sstmd_in_if.sink     i_in,
    sstmd_out_if.source  o_out
);
    import sstmd_pkg::*;

    // front end to queue
    t_cmd      f_cmd;
    logic      f_valid;
    logic      f_ready;

    // queue to back end
    t_cmd      q_cmd;
    logic      q_valid;
    logic      q_ready;
    t_q_status q_status;

    // decode and character map
    sstmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (f_cmd),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready)
    );

    // decouples decode from execution so either side can stall alone
    sstmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (f_cmd),
        .i_valid  (f_valid),
        .o_ready  (f_ready),
        .o_cmd    (q_cmd),
        .o_valid  (q_valid),
        .i_ready  (q_ready),
        .o_status (q_status)
    );

    // digit store, placement rules and refresh scan with output register
    sstmd_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .o_out       (o_out)
    );

    // queue can never claim to be both full and empty
    `SSTMD_ASSERT_IMPL(a_q_status, 1'b1, !(q_status.full && q_status.empty))
    // a decoded command waiting on a full queue is still there next cycle
    `SSTMD_ASSERT_NEXT(a_front_hold, f_valid && !f_ready, f_valid)
    // at most one digit lit per refresh transaction
    `SSTMD_ASSERT_IMPL(a_one_digit, o_out.valid, $onehot0(o_out.digit_enables))
    // non-tick commands never wait on the output side
    `SSTMD_ASSERT_IMPL(a_no_block, q_valid && (q_cmd.kind != KIND_TICK), q_ready)

endmodule

`default_nettype wire

/* sim/seven_segment_text_mux_driver_test.sv */
// ----------------------------------------------------------------------------
// seven_segment_text_mux_driver_test
// feeds text strings and refresh ticks through the input channel, predicts
// every display frame from its own model of the digit store and scan, and
// checks each frame on the output channel field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seven_segment_text_mux_driver_test;

    import sstmd_pkg::*;

    localparam int DIGITS = DIGITS_DEF;

    // mode 3 has no meaning, the block drops it
    localparam t_mode MODE_VOID = 2'd3;

    // run bounds
    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned HOLD_AFTER   = 120;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        t_mode mode;
        t_char ch;
    } t_text_item;

    typedef struct packed {
        t_seg segs;
        t_en  en;
    } t_frame;

    logic i_clk;
    logic i_rst_n;

    sstmd_in_if  text_ch ();
    sstmd_out_if disp_ch ();

    seven_segment_text_mux_driver #(
        .DIGITS (DIGITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_ch),
        .o_out   (disp_ch)
    );

    // ------------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // display model: digit store, text cursor and refresh scan
    // ------------------------------------------------------------------------
    t_seg        shown [DIGITS];
    int unsigned cursor;
    bit          after_dot;
    bit          any_char;
    bit          halted;
    int unsigned scan_pos;

    t_frame frames_due [$];

    // what the run went through
    int unsigned starts_seen   = 0;
    int unsigned chars_seen    = 0;
    int unsigned ticks_seen    = 0;
    int unsigned error_fills   = 0;
    int unsigned overflows     = 0;
    int unsigned frames_match  = 0;
    int unsigned fail_count    = 0;

    function automatic t_seg numeral_glyph(input int unsigned d);
        case (d)
            0:       return 8'h3F;
            1:       return 8'h06;
            2:       return 8'h5B;
            3:       return 8'h4F;
            4:       return 8'h66;
            5:       return 8'h6D;
            6:       return 8'h7D;
            7:       return 8'h07;
            8:       return 8'h7F;
            default: return 8'h6F;
        endcase
    endfunction

    // segment pattern of a character, returns 0 when it has none
    function automatic bit char_glyph(input t_char c, output t_seg g);
        g = SEG_BLANK;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            g = numeral_glyph(int'(c - CHAR_ZERO));
            return 1'b1;
        end
        case (c)
            CHAR_DOT:   g = SEG_DOT;
            CHAR_DASH:  g = SEG_DASH;
            CHAR_SPACE: g = SEG_BLANK;
            default:    return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic clear_text();
        for (int i = 0; i < DIGITS; i++) shown[i] = SEG_BLANK;
        cursor    = 0;
        after_dot = 1'b0;
        any_char  = 1'b0;
        halted    = 1'b0;
    endtask

    task automatic place_char(input t_char c);
        bit          is_dot;
        int unsigned target;
        t_seg        glyph;
        bit          known;
        // a halted string drops everything up to the next start
        if (halted) return;
        // nul ends the string without touching the digits
        if (c == CHAR_NUL) begin
            halted = 1'b1;
            return;
        end
        is_dot = (c == CHAR_DOT);
        target = cursor;
        // a dot right after a non-dot lands on the digit just written
        if (any_char && (after_dot || !is_dot)) target = cursor + 1;
        // running off the last digit halts quietly
        if (target >= DIGITS) begin
            halted = 1'b1;
            overflows++;
            return;
        end
        known = char_glyph(c, glyph);
        // unknown character: every digit shows the error pattern
        if (!known) begin
            for (int i = 0; i < DIGITS; i++) shown[i] = SEG_ERROR;
            halted = 1'b1;
            error_fills++;
            return;
        end
        cursor         = target;
        shown[target]  = shown[target] | glyph;
        after_dot      = is_dot;
        any_char       = 1'b1;
    endtask

    task automatic apply_text_item(input t_mode m, input t_char c);
        t_frame f;
        case (m)
            MODE_START: begin
                clear_text();
                starts_seen++;
            end
            MODE_CHAR: begin
                place_char(c);
                chars_seen++;
            end
            MODE_TICK: begin
                // segment lines are active low, enables run in reverse order
                f.segs = ~shown[scan_pos];
                f.en   = t_en'(1 << (DIGITS - 1 - scan_pos));
                frames_due.push_back(f);
                scan_pos = (scan_pos + 1) % DIGITS;
                ticks_seen++;
            end
            default: ;
        endcase
    endtask

    initial begin
        clear_text();
        scan_pos = 0;
    end

    // ------------------------------------------------------------------------
    // idle pattern: mostly back to back or short, now and then long, with
    // stretches of no idling at all
    // ------------------------------------------------------------------------
    function automatic int unsigned next_gap(inout int unsigned burst);
        int unsigned r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // text driver: one transaction offered at a time from the pending queue
    // ------------------------------------------------------------------------
    t_text_item  text_items [$];
    t_text_item  offered;
    bit          offer_live = 1'b0;
    bit          go         = 1'b0;
    int unsigned tx_gap     = 0;
    int unsigned tx_burst   = 0;
    int unsigned sent_items = 0;

    always @(negedge i_clk) begin
        if (go && !offer_live) begin
            if (tx_gap > 0) begin
                tx_gap--;
                text_ch.valid <= 1'b0;
            end else if (text_items.size() > 0) begin
                offered = text_items.pop_front();
                text_ch.valid <= 1'b1;
                text_ch.mode  <= offered.mode;
                text_ch.ch    <= offered.ch;
                offer_live    = 1'b1;
                tx_gap        = next_gap(tx_burst);
            end else begin
                text_ch.valid <= 1'b0;
            end
        end
    end

    // accepted text transactions update the model right at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && text_ch.valid && text_ch.ready) begin
            apply_text_item(text_ch.mode, text_ch.ch);
            offer_live = 1'b0;
            sent_items++;
        end
    end

    // ------------------------------------------------------------------------
    // display receiver: random stalls plus one long hold-off so the command
    // queue fills and the input side backs up
    // ------------------------------------------------------------------------
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned rx_gap       = 0;
    int unsigned rx_burst     = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            disp_ch.ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            disp_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            disp_ch.ready <= 1'b0;
        end else begin
            disp_ch.ready <= 1'b1;
            rx_gap = next_gap(rx_burst);
        end
    end

    // ------------------------------------------------------------------------
    // frame checker: oldest expected frame against each accepted frame
    // ------------------------------------------------------------------------
    t_frame seen_frame;
    bit     frame_ok;

    always @(posedge i_clk) begin
        if (i_rst_n && disp_ch.valid && disp_ch.ready) begin
            if (frames_due.size() == 0) begin
                $error("unexpected display frame: segment_lines %02h, digit_enables %01h",
                       disp_ch.segment_lines, disp_ch.digit_enables);
                fail_count++;
            end else begin
                seen_frame = frames_due.pop_front();
                frame_ok   = 1'b1;
                if (disp_ch.segment_lines !== seen_frame.segs) begin
                    $error("segment_lines: expected %02h, actual %02h",
                           seen_frame.segs, disp_ch.segment_lines);
                    fail_count++;
                    frame_ok = 1'b0;
                end
                if (disp_ch.digit_enables !== seen_frame.en) begin
                    $error("digit_enables: expected %01h, actual %01h",
                           seen_frame.en, disp_ch.digit_enables);
                    fail_count++;
                    frame_ok = 1'b0;
                end
                if (frame_ok) frames_match++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    int unsigned queued_items = 0;

    task automatic queue_item(input t_mode m, input t_char c);
        t_text_item it;
        it.mode = m;
        it.ch   = c;
        text_items.push_back(it);
        // dropped modes do not count toward the run length
        if (m != MODE_VOID) queued_items++;
    endtask

    // mostly printable text, some nul and arbitrary bytes
    function automatic t_char pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return t_char'(CHAR_ZERO + $urandom_range(0, 9));
        if (r < 70) return CHAR_DOT;
        if (r < 78) return CHAR_DASH;
        if (r < 84) return CHAR_SPACE;
        if (r < 88) return CHAR_NUL;
        return t_char'($urandom_range(0, 255));
    endfunction

    initial begin
        int unsigned r;
        int unsigned n;

        text_ch.valid = 1'b0;
        text_ch.mode  = MODE_START;
        text_ch.ch    = CHAR_NUL;
        disp_ch.ready = 1'b0;
        i_rst_n       = 1'b0;

        // directed: blank scan after reset, text without a start
        queue_item(MODE_TICK,  8'hFF);
        queue_item(MODE_CHAR,  8'h38);
        // dot merges into the eight, a second dot takes its own digit
        queue_item(MODE_CHAR,  CHAR_DOT);
        queue_item(MODE_CHAR,  CHAR_DOT);
        queue_item(MODE_CHAR,  CHAR_DASH);
        queue_item(MODE_CHAR,  CHAR_NINE);
        // one past the last digit halts without a change
        queue_item(MODE_CHAR,  CHAR_ZERO);
        queue_item(MODE_VOID,  8'hFF);
        for (int i = 0; i < DIGITS; i++) queue_item(MODE_TICK, 8'h00);
        // unknown character fills the error pattern, later text is dropped
        queue_item(MODE_START, 8'hA5);
        queue_item(MODE_CHAR,  CHAR_SPACE);
        queue_item(MODE_CHAR,  8'hFF);
        queue_item(MODE_CHAR,  8'h31);
        queue_item(MODE_TICK,  8'h5A);
        // nul ends the string early
        queue_item(MODE_START, 8'h00);
        queue_item(MODE_CHAR,  CHAR_NUL);
        queue_item(MODE_CHAR,  8'h35);
        queue_item(MODE_TICK,  8'h00);
        // leading dot sits on the first digit
        queue_item(MODE_START, 8'hFF);
        queue_item(MODE_CHAR,  CHAR_DOT);
        queue_item(MODE_CHAR,  8'h37);
        queue_item(MODE_TICK,  8'hFF);

        // random: mostly whole strings followed by a scan, some noise
        while (queued_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                queue_item(MODE_START, t_char'($urandom_range(0, 255)));
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    queue_item(MODE_CHAR, pick_char());
                    if ($urandom_range(0, 3) == 0)
                        queue_item(MODE_TICK, t_char'($urandom_range(0, 255)));
                end
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    queue_item(MODE_TICK, t_char'($urandom_range(0, 255)));
            end else if (r < 88) begin
                queue_item(MODE_VOID, t_char'($urandom_range(0, 255)));
            end else begin
                queue_item(t_mode'($urandom_range(0, 2)), t_char'($urandom_range(0, 255)));
            end
        end

        // reset, released on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        go = 1'b1;

        // long receiver hold-off while text keeps coming
        wait (sent_items >= HOLD_AFTER);
        hold_request = 1'b1;

        // all text in, all frames out, then let the pipeline settle
        wait (text_items.size() == 0 && !offer_live);
        wait (frames_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d text transactions (%0d starts, %0d characters, %0d ticks)",
                 sent_items, starts_seen, chars_seen, ticks_seen);
        $display("run: %0d frames matched, %0d error fills, %0d digit overflows",
                 frames_match, error_fills, overflows);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
